// ===== src/apf_pkg.sv =====
package apf_pkg;

	localparam int DEPTH     = 16;
	localparam int ID_BITS   = 8;
	localparam int PRIO_BITS = 4;
	localparam int PRIO_MAX  = 15;
	localparam int CNT_BITS  = $clog2(DEPTH + 1);

	localparam int ST_BITS     = 2;
	localparam int IN_DATA_W   = ((ID_BITS + PRIO_BITS + 7) / 8) * 8;
	localparam int OUT_PAYLOAD = ST_BITS + ID_BITS + CNT_BITS;
	localparam int OUT_DATA_W  = ((OUT_PAYLOAD + 7) / 8) * 8;

	typedef enum logic [ST_BITS-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_EMPTY   = 2'd2,
		ST_BADPRIO = 2'd3
	} status_t;

	typedef enum logic {
		ACT_INSERT   = 1'b0,
		ACT_RETRIEVE = 1'b1
	} action_t;

	// controller to datapath
	typedef struct packed {
		logic capture;   // latch the incoming request
		logic execute;   // apply the request and load the result register
	} apf_cmd_t;

endpackage

// ===== src/apf_ctrl.sv =====
module apf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output apf_pkg::apf_cmd_t  cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free   = !out_valid_q || out_ready;
	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign cmd.capture = in_valid && in_ready;
	assign cmd.execute = (state_q == S_EXEC) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (out_ready)
						out_valid_q <= 1'b0;
					if (cmd.capture)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					// hold here until the result register can take the beat
					if (slot_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== src/apf_datapath.sv =====
module apf_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  apf_pkg::apf_cmd_t               cmd,
	input  logic                            req_action,
	input  logic [apf_pkg::ID_BITS-1:0]     req_id,
	input  logic [apf_pkg::PRIO_BITS-1:0]   req_prio,
	output apf_pkg::status_t                res_status,
	output logic [apf_pkg::ID_BITS-1:0]     res_id,
	output logic [apf_pkg::CNT_BITS-1:0]    res_occupancy
);

	localparam int D = apf_pkg::DEPTH;

	logic [apf_pkg::ID_BITS-1:0]   id_q   [D];
	logic [apf_pkg::PRIO_BITS-1:0] prio_q [D];
	logic [apf_pkg::CNT_BITS-1:0]  count_q;

	logic                          act_q;
	logic [apf_pkg::ID_BITS-1:0]   new_id_q;
	logic [apf_pkg::PRIO_BITS-1:0] new_prio_q;

	apf_pkg::status_t              status_q;
	logic [apf_pkg::ID_BITS-1:0]   out_id_q;
	logic [apf_pkg::CNT_BITS-1:0]  occ_q;

	apf_pkg::status_t              status_c;
	logic [apf_pkg::CNT_BITS-1:0]  count_c;
	logic                          do_insert;
	logic                          do_retrieve;
	logic [D-1:0]                  gt;

	function automatic logic [apf_pkg::PRIO_BITS-1:0] age(
		input logic [apf_pkg::PRIO_BITS-1:0] p
	);
		return (p > apf_pkg::PRIO_BITS'(1)) ? p - apf_pkg::PRIO_BITS'(1) : p;
	endfunction

	always_comb begin
		status_c    = apf_pkg::ST_OK;
		count_c     = count_q;
		do_insert   = 1'b0;
		do_retrieve = 1'b0;
		if (act_q == apf_pkg::ACT_INSERT) begin
			if (new_prio_q == '0 ||
			    32'(new_prio_q) > apf_pkg::PRIO_MAX) begin
				status_c = apf_pkg::ST_BADPRIO;
			end else if (count_q == apf_pkg::CNT_BITS'(D)) begin
				status_c = apf_pkg::ST_FULL;
			end else begin
				do_insert = 1'b1;
				count_c   = count_q + apf_pkg::CNT_BITS'(1);
			end
		end else begin
			if (count_q == '0) begin
				status_c = apf_pkg::ST_EMPTY;
			end else begin
				do_retrieve = 1'b1;
				count_c     = count_q - apf_pkg::CNT_BITS'(1);
			end
		end
	end

	// request and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q      <= req_action;
			new_id_q   <= req_id;
			new_prio_q <= req_prio;
		end
		if (cmd.execute) begin
			status_q <= status_c;
			out_id_q <= do_retrieve ? id_q[0] : '0;
			occ_q    <= count_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (cmd.execute)
			count_q <= count_c;
	end

	// cells stay sorted by priority, front at index 0; empty cells count as greater
	for (genvar i = 0; i < D; i++) begin : g_cell
		assign gt[i] = (apf_pkg::CNT_BITS'(i) < count_q) ? (prio_q[i] > new_prio_q) : 1'b1;

		always_ff @(posedge clk) begin
			if (cmd.execute && do_insert && gt[i]) begin
				if (i == 0) begin
					id_q[i]   <= new_id_q;
					prio_q[i] <= new_prio_q;
				end else if (!gt[(i == 0) ? 0 : i-1]) begin
					id_q[i]   <= new_id_q;
					prio_q[i] <= new_prio_q;
				end else begin
					id_q[i]   <= id_q[(i == 0) ? 0 : i-1];
					prio_q[i] <= prio_q[(i == 0) ? 0 : i-1];
				end
			end else if (cmd.execute && do_retrieve && i < D-1) begin
				// advance toward the front and age
				id_q[i]   <= id_q[(i < D-1) ? i+1 : i];
				prio_q[i] <= age(prio_q[(i < D-1) ? i+1 : i]);
			end
		end
	end

	assign res_status    = status_q;
	assign res_id        = out_id_q;
	assign res_occupancy = occ_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= apf_pkg::CNT_BITS'(D))
		else $error("entry count above depth");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute && do_insert |=> count_q == $past(count_q) + apf_pkg::CNT_BITS'(1))
		else $error("accepted insert did not add an entry");

	a_reject_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.execute && status_c != apf_pkg::ST_OK |=> $stable(count_q))
		else $error("rejected request changed the count");

	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= apf_pkg::CNT_BITS'(2) |-> prio_q[0] <= prio_q[1])
		else $error("front entries out of priority order");

endmodule

// ===== src/aging_priority_fifo.sv =====
// Bounded priority queue with aging, sixteen entries of id and priority.
// Request channel s_*: s_tuser carries the action (0 insert, 1 retrieve),
// s_tdata carries the id and the priority. Priority 1 is most urgent; an
// insert lands behind every held entry of equal or better priority.
// Result channel m_*: one beat per request with the status code (ok, full,
// empty, bad priority), the id removed by a good retrieve (else zero) and
// the occupancy after the request.
// A retrieve also ages the remaining entries: each priority above 1 drops
// by one.
// A request is latched into the request register, then the cell array
// shifts and ages and the result register loads, once it can take the beat;
// no new request is taken until then.
// The result register frees the request side: a new request is taken while
// the previous result waits. When m_tready stays low, the block holds the
// next finished request until the result register drains.
// Reset empties the queue and drops any pending result beat.
module aging_priority_fifo (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [apf_pkg::IN_DATA_W-1:0]   s_tdata,   // [7:0] item_id, [11:8] item_priority
	input  logic                            s_tuser,   // [0] action
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [apf_pkg::OUT_DATA_W-1:0]  m_tdata    // [1:0] status, [9:2] out_id, [14:10] occupancy
);

	apf_pkg::apf_cmd_t              cmd;
	apf_pkg::status_t               res_status;
	logic [apf_pkg::ID_BITS-1:0]    res_id;
	logic [apf_pkg::CNT_BITS-1:0]   res_occupancy;

	apf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	apf_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.req_action    (s_tuser),
		.req_id        (s_tdata[apf_pkg::ID_BITS-1:0]),
		.req_prio      (s_tdata[apf_pkg::ID_BITS +: apf_pkg::PRIO_BITS]),
		.res_status    (res_status),
		.res_id        (res_id),
		.res_occupancy (res_occupancy)
	);

	assign m_tdata = apf_pkg::OUT_DATA_W'({res_occupancy, res_id, res_status});

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int N_RANDOM  = 1426;
	localparam int HOLD_LEN  = 64;
	localparam int DRAIN_CYC = 10;

	typedef struct {
		apf_pkg::action_t                act;
		logic [apf_pkg::ID_BITS-1:0]     id;
		logic [apf_pkg::PRIO_BITS-1:0]   prio;
	} request_t;

	typedef struct {
		logic [apf_pkg::ID_BITS-1:0]     id;
		logic [apf_pkg::PRIO_BITS-1:0]   prio;
	} entry_t;

	typedef struct {
		apf_pkg::status_t                st;
		logic [apf_pkg::ID_BITS-1:0]     id;
		logic [apf_pkg::CNT_BITS-1:0]    occ;
	} result_t;

	logic                              clk      = 1'b0;
	logic                              arst_n   = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [apf_pkg::IN_DATA_W-1:0]     s_tdata  = '0;
	logic                              s_tuser  = 1'b0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [apf_pkg::OUT_DATA_W-1:0]    m_tdata;

	request_t requests[$];
	result_t  pending_results[$];
	entry_t   held[$];
	request_t cur_req;
	int       n_total;
	int       n_sent    = 0;
	int       n_errors  = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;

	aging_priority_fifo u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one request to the shadow queue and return the beat it should produce.
	function automatic result_t serve_request(request_t rq);
		result_t r;
		entry_t  e;
		int      pos;
		r.st = apf_pkg::ST_OK;
		r.id = '0;
		if (rq.act == apf_pkg::ACT_INSERT) begin
			if (rq.prio == 0 || rq.prio > apf_pkg::PRIO_MAX) begin
				r.st = apf_pkg::ST_BADPRIO;
			end else if (held.size() >= apf_pkg::DEPTH) begin
				r.st = apf_pkg::ST_FULL;
			end else begin
				// walk back from the tail past every entry of worse priority
				pos = held.size();
				while (pos > 0 && held[pos-1].prio > rq.prio)
					pos--;
				e.id   = rq.id;
				e.prio = rq.prio;
				held.insert(pos, e);
			end
		end else if (held.size() == 0) begin
			r.st = apf_pkg::ST_EMPTY;
		end else begin
			e = held.pop_front();
			r.id = e.id;
			// age the remaining entries
			foreach (held[i])
				if (held[i].prio > 1)
					held[i].prio = held[i].prio - 1'b1;
		end
		r.occ = apf_pkg::CNT_BITS'(held.size());
		return r;
	endfunction

	function automatic int send_idle_pct();
		if (n_sent < n_total / 3)
			return 17;
		else if (n_sent < 2 * n_total / 3)
			return 66;
		return 0;
	endfunction

	function automatic int recv_idle_pct();
		if (n_sent < n_total / 3)
			return 66;
		else if (n_sent < 2 * n_total / 3)
			return 17;
		return 0;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		n_errors++;
	endtask

	task automatic check_result(logic [apf_pkg::OUT_DATA_W-1:0] beat);
		result_t want;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("unexpected result beat 0x%h", beat));
			return;
		end
		want = pending_results.pop_front();
		if (beat[1:0] != want.st)
			report_mismatch($sformatf("status got %0d want %0d", beat[1:0], want.st));
		if (beat[9:2] != want.id)
			report_mismatch($sformatf("out_id got 0x%h want 0x%h", beat[9:2], want.id));
		if (beat[14:10] != want.occ)
			report_mismatch($sformatf("occupancy got %0d want %0d", beat[14:10], want.occ));
	endtask

	task automatic add_req(apf_pkg::action_t act, logic [apf_pkg::ID_BITS-1:0] id,
			logic [apf_pkg::PRIO_BITS-1:0] prio);
		request_t rq;
		rq.act  = act;
		rq.id   = id;
		rq.prio = prio;
		requests.push_back(rq);
	endtask

	// Request side: advance on acceptance, idle at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				pending_results.push_back(serve_request(cur_req));
				n_sent++;
			end
			if (!s_tvalid || s_tready) begin
				if (requests.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
					cur_req = requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= {{(apf_pkg::IN_DATA_W-apf_pkg::ID_BITS-apf_pkg::PRIO_BITS){1'b0}},
						cur_req.prio, cur_req.id};
					s_tuser  <= cur_req.act;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Result side: check each beat, stall at random, hold off once for a long stretch.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			if (!hold_done && n_sent >= 2 * n_total / 3 + 50) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_idle_pct());
			end
		end
	end

	initial begin
		int mode;
		int burst;
		int ins_pct;
		int n_rand;
		int r;
		logic [apf_pkg::PRIO_BITS-1:0] p;

		// empty retrieve and bad priority on an empty queue
		add_req(apf_pkg::ACT_RETRIEVE, 8'h5A, 4'd7);
		add_req(apf_pkg::ACT_INSERT, 8'hAA, 4'd0);
		// fill up with id and priority extremes and ties
		for (int i = 0; i < apf_pkg::DEPTH; i++) begin
			p = apf_pkg::PRIO_BITS'(apf_pkg::PRIO_MAX - ((i * 7) % 15));
			add_req(apf_pkg::ACT_INSERT,
				(i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(255)), p);
		end
		add_req(apf_pkg::ACT_INSERT, 8'h33, 4'd5);
		// bad priority wins over full
		add_req(apf_pkg::ACT_INSERT, 8'hCC, 4'd0);
		for (int i = 0; i < 4; i++)
			add_req(apf_pkg::ACT_RETRIEVE, 8'($urandom_range(255)), 4'($urandom_range(15)));

		// bursts that lean toward filling, draining or neither
		n_rand = 0;
		while (n_rand < N_RANDOM) begin
			mode    = $urandom_range(2);
			burst   = $urandom_range(20, 60);
			ins_pct = (mode == 0) ? 80 : (mode == 1) ? 20 : 50;
			for (int k = 0; k < burst && n_rand < N_RANDOM; k++) begin
				r = $urandom_range(99);
				if (r < 6)
					p = 4'd0;
				else if (r < 40)
					p = 4'($urandom_range(1, 3));
				else
					p = 4'($urandom_range(1, apf_pkg::PRIO_MAX));
				if ($urandom_range(99) < ins_pct)
					add_req(apf_pkg::ACT_INSERT, 8'($urandom_range(255)), p);
				else
					add_req(apf_pkg::ACT_RETRIEVE, 8'($urandom_range(255)),
						4'($urandom_range(15)));
				n_rand++;
			end
		end
		n_total = requests.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (requests.size() > 0 || s_tvalid || pending_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (n_errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== sim.f =====
src/apf_pkg.sv
src/apf_ctrl.sv
src/apf_datapath.sv
src/aging_priority_fifo.sv
tb/sv/tb.sv
